// ----- design/acr_pkg.sv -----
// Package for the box contact resolver: shared widths, the contact job record
// passed from the front end through the queue to the back end, and defaults.
// No dependencies.
`default_nettype none
package acr_pkg;
	localparam int unsigned VAL_W = 32;
	localparam int unsigned QDEPTH_DEF = 2;
	localparam int unsigned IN_DATA_W = 296;
	localparam int unsigned OUT_DATA_W = 296;

	// One contact, classified and ready for the push and velocity stage.
	typedef struct packed {
		logic                       touch;
		logic [VAL_W-1:0]           pen;
		logic                       ax;
		logic                       neg;
		logic                       mv_a;
		logic                       mv_b;
		logic                       dyn_a;
		logic                       dyn_b;
		logic [VAL_W-1:0]           ma;
		logic [VAL_W-1:0]           mb;
		logic [1:0][VAL_W-1:0]      a_pos;
		logic [1:0][VAL_W-1:0]      a_vel;
		logic [1:0][VAL_W-1:0]      b_pos;
		logic [1:0][VAL_W-1:0]      b_vel;
	} job_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_FIN  = 4'b1000
	} bk_state_t;
endpackage
`default_nettype wire

// ----- design/acr_front.sv -----
// Front end: accepts body requests, holds body A and classifies a contact
// when body B arrives. Depends on acr_pkg.
`default_nettype none
module acr_front
	import acr_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic             in_b,
	input  wire logic [VAL_W-1:0] min_x,
	input  wire logic [VAL_W-1:0] min_y,
	input  wire logic [VAL_W-1:0] max_x,
	input  wire logic [VAL_W-1:0] max_y,
	input  wire logic [VAL_W-1:0] px,
	input  wire logic [VAL_W-1:0] py,
	input  wire logic [VAL_W-1:0] vx,
	input  wire logic [VAL_W-1:0] vy,
	input  wire logic [VAL_W-1:0] mass,
	input  wire logic             dyn,
	input  wire logic             q_full,
	output logic                  in_ready,
	output logic                  push,
	output job_t                  job
);
	logic [3:0][VAL_W-1:0] box_q;
	logic [1:0][VAL_W-1:0] pos_q;
	logic [1:0][VAL_W-1:0] vel_q;
	logic [VAL_W-1:0]      mass_q;
	logic                  dyn_q;
	logic                  held_q;

	logic signed [VAL_W-1:0] hi_x, hi_y, lo_x, lo_y;
	logic signed [VAL_W:0]   ox, oy, delta;
	logic                    touch, ax, accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && in_b && held_q;

	always_comb begin
		hi_x  = ($signed(box_q[2]) < $signed(max_x)) ? $signed(box_q[2]) : $signed(max_x);
		hi_y  = ($signed(box_q[3]) < $signed(max_y)) ? $signed(box_q[3]) : $signed(max_y);
		lo_x  = ($signed(box_q[0]) > $signed(min_x)) ? $signed(box_q[0]) : $signed(min_x);
		lo_y  = ($signed(box_q[1]) > $signed(min_y)) ? $signed(box_q[1]) : $signed(min_y);
		ox    = {hi_x[VAL_W-1], hi_x} - {lo_x[VAL_W-1], lo_x};
		oy    = {hi_y[VAL_W-1], hi_y} - {lo_y[VAL_W-1], lo_y};
		touch = (ox > 0) && (oy > 0);
		ax    = !(ox < oy);
		if (ax) begin
			delta = {py[VAL_W-1], py} - {pos_q[1][VAL_W-1], pos_q[1]};
		end else begin
			delta = {px[VAL_W-1], px} - {pos_q[0][VAL_W-1], pos_q[0]};
		end
		job.touch = touch;
		job.pen   = !touch ? '0 : (ax ? oy[VAL_W-1:0] : ox[VAL_W-1:0]);
		job.ax    = touch && ax;
		job.neg   = touch && delta[VAL_W];
		job.mv_a  = touch && dyn_q && (mass_q != '0);
		job.mv_b  = touch && dyn && (mass != '0);
		job.dyn_a = dyn_q;
		job.dyn_b = dyn;
		job.ma    = mass_q;
		job.mb    = mass;
		job.a_pos = pos_q;
		job.a_vel = vel_q;
		job.b_pos = {py, px};
		job.b_vel = {vy, vx};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 1'b0;
			box_q  <= '0;
			pos_q  <= '0;
			vel_q  <= '0;
			mass_q <= '0;
			dyn_q  <= 1'b0;
		end else if (accept) begin
			if (!in_b) begin
				held_q <= 1'b1;
				box_q  <= {max_y, max_x, min_y, min_x};
				pos_q  <= {py, px};
				vel_q  <= {vy, vx};
				mass_q <= mass;
				dyn_q  <= dyn;
			end else begin
				held_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

// ----- design/acr_queue.sv -----
// Short job queue between the front and back ends.
// Depends on acr_pkg for the job record.
`default_nettype none
module acr_queue
	import acr_pkg::*;
#(
	parameter int unsigned DEPTH = QDEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  job_t      wdata,
	input  wire logic pop,
	output job_t      rdata,
	output logic      full,
	output logic      empty
);
	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == LAST) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == LAST) ? '0 : rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

// ----- design/acr_back.sv -----
// Back end: splits the penetration by inverse mass with a multiplier and a
// bit-serial divider, applies pushes and velocity clamps, holds the result.
// Depends on acr_pkg.
`default_nettype none
module acr_back
	import acr_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic q_empty,
	input  job_t      q_job,
	output logic      pop,
	output logic      out_valid,
	input  wire logic out_ready,
	output logic [OUT_DATA_W-1:0] out_data
);
	localparam int unsigned CNT_W = $clog2(VAL_W);

	bk_state_t           state_q;
	job_t                job_q;
	logic [VAL_W:0]      rem_q, dvs_q;
	logic [VAL_W-1:0]    lo_q, quo_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [2*VAL_W-1:0]  prod;
	logic [VAL_W+1:0]    trial, tsub;
	logic                both, fin_go;

	logic [VAL_W-1:0]        corr_a, corr_b;
	logic [1:0][VAL_W-1:0]   na_pos, nb_pos, na_vel, nb_vel;
	logic signed [VAL_W+1:0] sa, sb;
	logic [OUT_DATA_W-1:0]   out_q;

	function automatic logic [VAL_W-1:0] sat(input logic signed [VAL_W+1:0] v);
		logic signed [VAL_W+1:0] hi, lo;
		hi = (VAL_W+2)'(2**(VAL_W-1) - 1);
		lo = -(VAL_W+2)'(2**(VAL_W-1));
		if (v > hi) begin
			return hi[VAL_W-1:0];
		end else if (v < lo) begin
			return lo[VAL_W-1:0];
		end
		return v[VAL_W-1:0];
	endfunction

	assign both   = job_q.mv_a && job_q.mv_b;
	assign pop    = (state_q == ST_IDLE) && !q_empty;
	assign prod   = job_q.pen * job_q.mb;
	assign trial  = {rem_q, lo_q[VAL_W-1]};
	assign tsub   = trial - {1'b0, dvs_q};
	assign fin_go = (state_q == ST_FIN) && (!out_valid || out_ready);

	always_comb begin
		if (both) begin
			corr_a = quo_q;
			// The two floor shares add to pen, or pen - 1 when the split is inexact.
			corr_b = job_q.pen - quo_q - VAL_W'(rem_q != '0);
		end else begin
			corr_a = job_q.mv_a ? job_q.pen : '0;
			corr_b = job_q.mv_b ? job_q.pen : '0;
		end
		na_pos = job_q.a_pos;
		nb_pos = job_q.b_pos;
		na_vel = job_q.a_vel;
		nb_vel = job_q.b_vel;
		if (job_q.neg) begin
			sa = $signed({{2{job_q.a_pos[job_q.ax][VAL_W-1]}}, job_q.a_pos[job_q.ax]})
				+ $signed({2'b00, corr_a});
			sb = $signed({{2{job_q.b_pos[job_q.ax][VAL_W-1]}}, job_q.b_pos[job_q.ax]})
				- $signed({2'b00, corr_b});
		end else begin
			sa = $signed({{2{job_q.a_pos[job_q.ax][VAL_W-1]}}, job_q.a_pos[job_q.ax]})
				- $signed({2'b00, corr_a});
			sb = $signed({{2{job_q.b_pos[job_q.ax][VAL_W-1]}}, job_q.b_pos[job_q.ax]})
				+ $signed({2'b00, corr_b});
		end
		if (job_q.mv_a || job_q.mv_b) begin
			na_pos[job_q.ax] = sat(sa);
			nb_pos[job_q.ax] = sat(sb);
			// A approaches when its velocity shares the normal's sign; B when opposed.
			if (job_q.dyn_a && (job_q.a_vel[job_q.ax] != '0)
				&& (job_q.a_vel[job_q.ax][VAL_W-1] == job_q.neg)) begin
				na_vel[job_q.ax] = '0;
			end
			if (job_q.dyn_b && (job_q.b_vel[job_q.ax] != '0)
				&& (job_q.b_vel[job_q.ax][VAL_W-1] != job_q.neg)) begin
				nb_vel[job_q.ax] = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= q_job;
		end
		case (state_q)
			ST_MUL: begin
				rem_q <= {1'b0, prod[2*VAL_W-1:VAL_W]};
				lo_q  <= prod[VAL_W-1:0];
				dvs_q <= {1'b0, job_q.ma} + {1'b0, job_q.mb};
				quo_q <= '0;
			end
			ST_DIV: begin
				lo_q <= {lo_q[VAL_W-2:0], 1'b0};
				if (!tsub[VAL_W+1]) begin
					rem_q <= tsub[VAL_W:0];
					quo_q <= {quo_q[VAL_W-2:0], 1'b1};
				end else begin
					rem_q <= trial[VAL_W:0];
					quo_q <= {quo_q[VAL_W-2:0], 1'b0};
				end
			end
			default: begin
			end
		endcase
		if (fin_go) begin
			out_q <= OUT_DATA_W'({nb_vel[1], nb_vel[0], nb_pos[1], nb_pos[0],
				na_vel[1], na_vel[0], na_pos[1], na_pos[0],
				job_q.neg, job_q.ax, job_q.pen, job_q.touch});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (fin_go) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					cnt_q   <= '0;
					state_q <= both ? ST_DIV : ST_FIN;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(VAL_W - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_data = out_q;

`ifndef SYNTHESIS
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (dvs_q != '0))
		else $error("divider runs with a zero mass sum");
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < dvs_q))
		else $error("partial remainder not below divisor");
	a_share_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && both) |-> (quo_q <= job_q.pen))
		else $error("share of A exceeds the penetration");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q == ST_MUL))
		else $error("job popped without starting");
`endif
endmodule
`default_nettype wire

// ----- design/aabb_contact_resolve_unit.sv -----
// Box contact resolver. A body A request returns nothing; a body B request
// with A held raises its result after the back end pops the job, multiplies,
// runs 32 divider steps when both bodies move, and finishes.
// The back end takes a new contact only once it has finished the last one;
// an unread result stalls it.
// Asynchronous active-low reset clears the held body, queue and result valid.
`default_nettype none
module aabb_contact_resolve_unit
	import acr_pkg::*;
#(
	parameter int unsigned QDEPTH = QDEPTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// tdata: box_min_x, box_min_y, box_max_x, box_max_y, pos_x, pos_y,
	// vel_x, vel_y, mass, dynamic, zero fill
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	// tuser: req_type
	input  wire logic                  s_axis_tuser,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// tdata: touching, penetration, normal_axis, normal_negative, new_a_pos_x,
	// new_a_pos_y, new_a_vel_x, new_a_vel_y, new_b_pos_x, new_b_pos_y,
	// new_b_vel_x, new_b_vel_y, zero fill
	output logic [OUT_DATA_W-1:0]      m_axis_tdata
);
	job_t f_job, q_job;
	logic push, pop, q_full, q_empty;

	acr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_b     (s_axis_tuser),
		.min_x    (s_axis_tdata[31:0]),
		.min_y    (s_axis_tdata[63:32]),
		.max_x    (s_axis_tdata[95:64]),
		.max_y    (s_axis_tdata[127:96]),
		.px       (s_axis_tdata[159:128]),
		.py       (s_axis_tdata[191:160]),
		.vx       (s_axis_tdata[223:192]),
		.vy       (s_axis_tdata[255:224]),
		.mass     (s_axis_tdata[287:256]),
		.dyn      (s_axis_tdata[288]),
		.q_full   (q_full),
		.in_ready (s_axis_tready),
		.push     (push),
		.job      (f_job)
	);

	acr_queue #(.DEPTH(QDEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (f_job),
		.pop    (pop),
		.rdata  (q_job),
		.full   (q_full),
		.empty  (q_empty)
	);

	acr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_job     (q_job),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);
endmodule
`default_nettype wire

// ----- sim/tb_aabb_contact_resolve_unit.sv -----
// Testbench for aabb_contact_resolve_unit: drives body A and body B requests
// with random bursts and output stalls, and checks every result field.
// Depends on acr_pkg and the unit's RTL.
`default_nettype none

class contact_scoreboard;
	bit [acr_pkg::OUT_DATA_W-1:0] pending_contacts[$];
	int mismatches;
	bit [31:0] held_box[4];
	bit [31:0] held_pos[2];
	bit [31:0] held_vel[2];
	bit [31:0] held_mass;
	bit held_dyn;
	bit held_valid;

	function new();
		mismatches = 0;
		held_valid = 0;
		held_dyn = 0;
		held_mass = '0;
		foreach (held_box[i]) held_box[i] = '0;
		foreach (held_pos[i]) begin
			held_pos[i] = '0;
			held_vel[i] = '0;
		end
	endfunction

	static function longint sat(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// Holds a body A request, or predicts the contact result of an accepted body B request.
	function void note_request(bit kind, bit [acr_pkg::IN_DATA_W-1:0] d);
		longint ab[4], bb[4], ap[2], bp[2], av[2], bv[2];
		longint ox, oy, pen, s;
		bit [63:0] ma, mb, corr_a, corr_b;
		bit touch, dyn_a, dyn_b, mv_a, mv_b, ax, neg;
		bit [acr_pkg::OUT_DATA_W-1:0] r;
		if (kind == 1'b0) begin
			for (int i = 0; i < 4; i++) held_box[i] = d[32*i +: 32];
			held_pos[0] = d[128 +: 32];
			held_pos[1] = d[160 +: 32];
			held_vel[0] = d[192 +: 32];
			held_vel[1] = d[224 +: 32];
			held_mass = d[256 +: 32];
			held_dyn = d[288];
			held_valid = 1;
			return;
		end
		if (!held_valid) return;
		held_valid = 0;
		for (int i = 0; i < 4; i++) begin
			ab[i] = longint'(signed'(held_box[i]));
			bb[i] = longint'(signed'(d[32*i +: 32]));
		end
		for (int i = 0; i < 2; i++) begin
			ap[i] = longint'(signed'(held_pos[i]));
			av[i] = longint'(signed'(held_vel[i]));
			bp[i] = longint'(signed'(d[128 + 32*i +: 32]));
			bv[i] = longint'(signed'(d[192 + 32*i +: 32]));
		end
		ma = {32'd0, held_mass};
		mb = {32'd0, d[256 +: 32]};
		dyn_a = held_dyn;
		dyn_b = d[288];
		ox = ((ab[2] < bb[2]) ? ab[2] : bb[2]) - ((ab[0] > bb[0]) ? ab[0] : bb[0]);
		oy = ((ab[3] < bb[3]) ? ab[3] : bb[3]) - ((ab[1] > bb[1]) ? ab[1] : bb[1]);
		touch = (ox > 0) && (oy > 0);
		pen = 0;
		ax = 0;
		neg = 0;
		if (touch) begin
			pen = (ox < oy) ? ox : oy;
			ax = (ox < oy) ? 1'b0 : 1'b1;
			neg = (bp[ax] - ap[ax]) < 0;
			s = neg ? -1 : 1;
			mv_a = dyn_a && ma != 0;
			mv_b = dyn_b && mb != 0;
			if (mv_a || mv_b) begin
				if (mv_a && mv_b) begin
					corr_a = (64'(pen) * mb) / (ma + mb);
					corr_b = (64'(pen) * ma) / (ma + mb);
				end else begin
					corr_a = mv_a ? 64'(pen) : 64'd0;
					corr_b = mv_b ? 64'(pen) : 64'd0;
				end
				ap[ax] = sat(ap[ax] - s * longint'(corr_a));
				bp[ax] = sat(bp[ax] + s * longint'(corr_b));
				if (dyn_a && av[ax] * s > 0) av[ax] = 0;
				if (dyn_b && bv[ax] * s < 0) bv[ax] = 0;
			end
		end
		r = '0;
		r[0] = touch;
		r[32:1] = pen[31:0];
		r[33] = ax;
		r[34] = neg;
		r[35 +: 32] = ap[0][31:0];
		r[67 +: 32] = ap[1][31:0];
		r[99 +: 32] = av[0][31:0];
		r[131 +: 32] = av[1][31:0];
		r[163 +: 32] = bp[0][31:0];
		r[195 +: 32] = bp[1][31:0];
		r[227 +: 32] = bv[0][31:0];
		r[259 +: 32] = bv[1][31:0];
		pending_contacts.insert(pending_contacts.size(), r);
	endfunction

	function void fail_note(string what, bit [31:0] e, bit [31:0] a);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch %s: expected %h actual %h", what, e, a);
	endfunction

	function void check_result(bit [acr_pkg::OUT_DATA_W-1:0] got);
		bit [acr_pkg::OUT_DATA_W-1:0] e;
		string names[12] = '{"touching", "penetration", "normal_axis", "normal_negative",
			"new_a_pos_x", "new_a_pos_y", "new_a_vel_x", "new_a_vel_y",
			"new_b_pos_x", "new_b_pos_y", "new_b_vel_x", "new_b_vel_y"};
		int offs[12] = '{0, 1, 33, 34, 35, 67, 99, 131, 163, 195, 227, 259};
		int wids[12] = '{1, 32, 1, 1, 32, 32, 32, 32, 32, 32, 32, 32};
		bit [31:0] fe, fa;
		if (pending_contacts.size() == 0) begin
			fail_note("unexpected result", 32'd0, got[31:0]);
			return;
		end
		e = pending_contacts.pop_front();
		for (int f = 0; f < 12; f++) begin
			fe = 32'(e[offs[f] +: 32] & ((64'd1 << wids[f]) - 1));
			fa = 32'(got[offs[f] +: 32] & ((64'd1 << wids[f]) - 1));
			if (fe != fa) fail_note(names[f], fe, fa);
		end
	endfunction
endclass

module tb_aabb_contact_resolve_unit;
	import acr_pkg::*;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata;
	logic s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	contact_scoreboard sb = new();
	int burst_left;
	int idle_cycles = 0;
	int cyc = 0;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam logic KIND_A = 1'b0;
	localparam logic KIND_B = 1'b1;

	aabb_contact_resolve_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Output stalls cycle through always ready, coin flips and a fixed pattern.
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
		case ((cyc / 300) % 3)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= $urandom_range(0, 1);
			default: m_axis_tready <= (cyc % 7) < 2;
		endcase
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_aabb_contact_resolve_unit NOT OK");
			$finish;
		end
	end

	function automatic logic [IN_DATA_W-1:0] pack_body(logic [31:0] mnx, logic [31:0] mny,
		logic [31:0] mxx, logic [31:0] mxy, logic [31:0] px, logic [31:0] py,
		logic [31:0] vx, logic [31:0] vy, logic [31:0] m, logic dyn);
		logic [IN_DATA_W-1:0] d;
		d = '0;
		d[255:0] = {vy, vx, py, px, mxy, mxx, mny, mnx};
		d[287:256] = m;
		d[288] = dyn;
		return d;
	endfunction

	task automatic send_request(logic kind, logic [IN_DATA_W-1:0] d);
		s_axis_tuser <= kind;
		s_axis_tdata <= d;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(kind, d);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 12);
			if ($urandom_range(0, 2) != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
		end
	endtask

	task automatic wait_drained();
		while (sb.pending_contacts.size() != 0) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_mass();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(1, 32'h0004_0000);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] rand_pos(longint c);
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFF0 + $urandom_range(0, 15);
			1: return 32'h8000_0000 + $urandom_range(0, 15);
			2: return $urandom;
			default: return 32'(c + $urandom_range(0, 32'h2_0000) - 32'h1_0000);
		endcase
	endfunction

	// A body boxed around a center; wide extents give big penetrations.
	function automatic logic [IN_DATA_W-1:0] rand_body(longint cx, longint cy);
		longint ex, ey;
		logic [31:0] vx, vy;
		if ($urandom_range(0, 5) == 0) begin
			ex = $urandom_range(0, 32'h7FFF_FFFF);
			ey = $urandom_range(0, 32'h7FFF_FFFF);
		end else begin
			ex = $urandom_range(0, 32'h4_0000);
			ey = $urandom_range(0, 32'h4_0000);
		end
		vx = ($urandom_range(0, 1)) ? $urandom : 32'($signed($urandom_range(0, 32'h2_0000)) - 32'sh1_0000);
		vy = ($urandom_range(0, 1)) ? $urandom : 32'($signed($urandom_range(0, 32'h2_0000)) - 32'sh1_0000);
		return pack_body(32'(cx - ex), 32'(cy - ey), 32'(cx + ex), 32'(cy + ey),
			rand_pos(cx), rand_pos(cy), vx, vy, rand_mass(), $urandom_range(0, 3) != 0);
	endfunction

	initial begin
		longint cx, cy;
		logic [31:0] one;
		one = 32'h0001_0000;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		burst_left = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// B with nothing held, then an A replaced by a second A.
		send_request(KIND_B, pack_body(0, 0, one, one, 0, 0, 0, 0, one, 1));
		send_request(KIND_A, pack_body('1, '1, '1, '1, '1, '1, '1, '1, '1, 1));
		send_request(KIND_A, pack_body(0, 0, 2*one, 2*one, 0, 0, one, one, one, 1));
		// Identical boxes tie on the overlap, zero delta, both move.
		send_request(KIND_B, pack_body(0, 0, 2*one, 2*one, 0, 0, -one, -one, one, 1));
		// Smaller x overlap with B to the left, only A moves.
		send_request(KIND_A, pack_body(0, 0, 4*one, 4*one, one, 0, -one, 0, 3*one, 1));
		send_request(KIND_B, pack_body(-one, 0, one, 4*one, 0, 0, one, 0, one, 0));
		// Edges touching only, no contact.
		send_request(KIND_A, pack_body(0, 0, one, one, 0, 0, one, one, one, 1));
		send_request(KIND_B, pack_body(one, 0, 2*one, one, one, 0, -one, 0, one, 1));
		// Nothing moves: dynamic with zero mass on both sides.
		send_request(KIND_A, pack_body(0, 0, 2*one, one, 0, 0, one, one, 0, 1));
		send_request(KIND_B, pack_body(one, 0, 3*one, 3*one, one, one, -one, -one, 0, 1));
		// Largest masses and saturating positions with a full-range penetration.
		send_request(KIND_A, pack_body(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			'1, 1));
		send_request(KIND_B, pack_body(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			'1, 1));
		// Inverted box A, then two static bodies with empty boxes.
		send_request(KIND_A, pack_body(4*one, 0, 0, 4*one, 0, 0, 0, 0, one, 1));
		send_request(KIND_B, pack_body(0, 0, 4*one, 4*one, 0, 0, 0, 0, one, 1));
		send_request(KIND_A, pack_body(0, 0, '0, '0, 0, 0, 0, 0, 0, 0));
		send_request(KIND_B, pack_body(0, 0, '0, '0, 0, 0, 0, 0, 0, 0));

		for (int n = 0; n < 255; n++) begin
			if (n == 120) begin
				s_axis_tvalid <= 1'b0;
				wait_drained();
				@(posedge clk);
			end
			cx = longint'(signed'(32'($urandom)));
			cy = longint'(signed'(32'($urandom)));
			case ($urandom_range(0, 9))
				0: send_request(KIND_B, rand_body(cx, cy));
				1: send_request(KIND_A, IN_DATA_W'({$urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom, $urandom, $urandom}));
				2: send_request(KIND_B, IN_DATA_W'({$urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom, $urandom, $urandom}));
				default: begin
					send_request(KIND_A, rand_body(cx, cy));
					send_request(KIND_B, rand_body(cx + $urandom_range(0, 32'h4_0000) - 32'h2_0000,
						cy + $urandom_range(0, 32'h4_0000) - 32'h2_0000));
				end
			endcase
		end
		s_axis_tvalid <= 1'b0;
		wait_drained();
		repeat (100) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_contacts.size() == 0)
			$display("tb_aabb_contact_resolve_unit OK");
		else
			$display("tb_aabb_contact_resolve_unit NOT OK");
		$finish;
	end
endmodule

`default_nettype wire

// ----- files.f -----
design/acr_pkg.sv
design/acr_front.sv
design/acr_queue.sv
design/acr_back.sv
design/aabb_contact_resolve_unit.sv
sim/tb_aabb_contact_resolve_unit.sv
